FILE: rtl/core/dhs_pkg.sv
// Shared types, widths and constants of the depth difference hole scorer.
// Used by every module of the block; depends on nothing else.
package dhs_pkg;

    // Field widths.
    localparam int DEPTH_W  = 16;
    localparam int TAG_W    = 8;
    localparam int CFG_W    = 17;
    localparam int PROB_W   = 16;
    localparam int CIDX_W   = 3;

    // Widths of the Gaussian exponent datapath.
    localparam int AZ_W     = 17;
    localparam int SQ_W     = 2 * AZ_W;
    localparam int DEN_W    = 2 * DEPTH_W;
    localparam int NUM_W    = 42;
    localparam int REM_W    = 44;
    localparam int ACC_W    = 17;
    localparam int PROD_W   = 33;

    // The exponent is computed in Q8 with twelve bits; 3072 and above underflows.
    localparam int EXP_BITS = 12;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_MIN_CUTOFF    = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_MAX_CUTOFF    = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_ASSIGN_METHOD = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_GAUSS_CENTER  = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_GAUSS_SPREAD  = 3'd4;

    // Reset values of the configuration registers.
    localparam logic signed [CFG_W-1:0] MIN_CUTOFF_RST   = 17'sd0;
    localparam logic signed [CFG_W-1:0] MAX_CUTOFF_RST   = 17'sd1000;
    localparam logic                    METHOD_RST       = 1'b0;
    localparam logic signed [CFG_W-1:0] GAUSS_CENTER_RST = 17'sd0;
    localparam logic [DEPTH_W-1:0]      GAUSS_SPREAD_RST = 16'd100;

    // Probability constants.
    localparam logic [PROB_W-1:0] PROB_ONE  = 16'hFFFF;
    localparam logic [PROB_W-1:0] PROB_ZERO = 16'h0000;
    localparam logic [ACC_W-1:0]  ACC_ONE   = 17'h10000;
    localparam logic [PROD_W-1:0] ROUND_Q16 = 33'd32768;

    // exp(-2^k/256) in Q0.16, rounded to nearest.
    localparam logic [15:0] EXP_FACTOR [EXP_BITS] = '{
        16'd65280, 16'd65026, 16'd64520, 16'd63520, 16'd61565, 16'd57835,
        16'd51039, 16'd39750, 16'd24109, 16'd8869,  16'd1200,  16'd22
    };

    // Per-item flags that travel alongside the arithmetic.
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic             assigned;
        logic             zero_diff;
        logic             zero_spread;
        logic             overflow;
    } dhs_meta_t;

    // One finished result item.
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic              assigned;
        logic [PROB_W-1:0] probability;
    } dhs_result_t;

endpackage

FILE: rtl/core/dhs_front.sv
// Front end: corner mean, depth difference, window test, squared terms and
// the numerator and limit of the exponent division. Depends on dhs_pkg.
module dhs_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [dhs_pkg::DEPTH_W-1:0]         corner_depth_0,
    input  logic [dhs_pkg::DEPTH_W-1:0]         corner_depth_1,
    input  logic [dhs_pkg::DEPTH_W-1:0]         corner_depth_2,
    input  logic [dhs_pkg::DEPTH_W-1:0]         corner_depth_3,
    input  logic [dhs_pkg::DEPTH_W-1:0]         keypoint_depth,
    input  logic [dhs_pkg::TAG_W-1:0]           hole_tag,
    input  logic signed [dhs_pkg::CFG_W-1:0]    min_cutoff,
    input  logic signed [dhs_pkg::CFG_W-1:0]    max_cutoff,
    input  logic signed [dhs_pkg::CFG_W-1:0]    gauss_center,
    input  logic [dhs_pkg::DEPTH_W-1:0]         gauss_spread,
    output logic                                out_valid,
    output dhs_pkg::dhs_meta_t                  out_meta,
    output logic [dhs_pkg::NUM_W-1:0]           out_num,
    output logic [dhs_pkg::DEN_W-1:0]           out_den
);
    import dhs_pkg::*;

    // Stage registers.
    logic                      v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic [TAG_W-1:0]          tag1_reg, tag2_reg, tag3_reg;
    logic [DEPTH_W-1:0]        kp1_reg;
    logic [DEPTH_W:0]          s01_reg, s23_reg;
    logic signed [CFG_W-1:0]   d2_reg;
    logic                      asg3_reg;
    logic signed [CFG_W:0]     z3_reg;
    dhs_meta_t                 meta4_reg, meta5_reg, meta6_reg;
    logic [SQ_W-1:0]           sq4_reg;
    logic [DEN_W-1:0]          s24_reg, den5_reg, den6_reg;
    logic [NUM_W-1:0]          num5_reg, num6_reg;
    logic [REM_W-1:0]          lim5_reg;

    // Next values.
    logic [DEPTH_W:0]          s01_next, s23_next;
    logic [DEPTH_W+1:0]        sum_all;
    logic [DEPTH_W-1:0]        mean;
    logic signed [CFG_W-1:0]   d2_next;
    logic                      asg3_next;
    logic signed [CFG_W:0]     z3_next;
    logic signed [CFG_W:0]     neg_z;
    logic [AZ_W-1:0]           az;
    dhs_meta_t                 meta4_next, meta6_next;
    logic [SQ_W-1:0]           sq4_next;
    logic [DEN_W-1:0]          s24_next;
    logic [NUM_W-1:0]          num5_next;
    logic [REM_W-1:0]          lim5_next;

    // Stage 1: pairwise corner sums.
    assign s01_next = {1'b0, corner_depth_0} + {1'b0, corner_depth_1};
    assign s23_next = {1'b0, corner_depth_2} + {1'b0, corner_depth_3};

    // Stage 2: floor of the corner mean and the signed depth difference.
    assign sum_all = {1'b0, s01_reg} + {1'b0, s23_reg};
    assign mean    = sum_all[DEPTH_W+1:2];
    assign d2_next = $signed({1'b0, kp1_reg}) - $signed({1'b0, mean});

    // Stage 3: strict window test and offset from the Gaussian centre.
    assign asg3_next = (d2_reg > min_cutoff) && (d2_reg < max_cutoff);
    assign z3_next   = $signed({d2_reg[CFG_W-1], d2_reg})
                     - $signed({gauss_center[CFG_W-1], gauss_center});

    // Stage 4: magnitude of the offset, then both squares.
    assign neg_z    = -z3_reg;
    assign az       = z3_reg[CFG_W] ? neg_z[AZ_W-1:0] : z3_reg[AZ_W-1:0];
    assign sq4_next = {{AZ_W{1'b0}}, az} * {{AZ_W{1'b0}}, az};
    assign s24_next = {{DEPTH_W{1'b0}}, gauss_spread} * {{DEPTH_W{1'b0}}, gauss_spread};

    always_comb
    begin
        meta4_next             = '0;
        meta4_next.tag         = tag3_reg;
        meta4_next.assigned    = asg3_reg;
        meta4_next.zero_diff   = (z3_reg == '0);
        meta4_next.zero_spread = (gauss_spread == '0);
    end

    // Stage 5: rounded numerator and the underflow limit 3072 times the divisor.
    assign num5_next = NUM_W'({sq4_reg, 7'b0}) + NUM_W'(s24_reg >> 1);
    assign lim5_next = REM_W'({s24_reg, 11'b0}) + REM_W'({s24_reg, 10'b0});

    // Stage 6: underflow flag.
    always_comb
    begin
        meta6_next          = meta5_reg;
        meta6_next.overflow = (REM_W'(num5_reg) >= lim5_reg);
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag1_reg  <= hole_tag;
            kp1_reg   <= keypoint_depth;
            s01_reg   <= s01_next;
            s23_reg   <= s23_next;
            tag2_reg  <= tag1_reg;
            d2_reg    <= d2_next;
            tag3_reg  <= tag2_reg;
            asg3_reg  <= asg3_next;
            z3_reg    <= z3_next;
            meta4_reg <= meta4_next;
            sq4_reg   <= sq4_next;
            s24_reg   <= s24_next;
            meta5_reg <= meta4_reg;
            num5_reg  <= num5_next;
            den5_reg  <= s24_reg;
            lim5_reg  <= lim5_next;
            meta6_reg <= meta6_next;
            num6_reg  <= num5_reg;
            den6_reg  <= den5_reg;
        end
    end

    assign out_valid = v6_reg;
    assign out_meta  = meta6_reg;
    assign out_num   = num6_reg;
    assign out_den   = den6_reg;

endmodule

FILE: rtl/core/dhs_div.sv
// Restoring divider that forms the twelve-bit Q8 exponent, one quotient bit
// per pipeline stage. Depends on dhs_pkg.
module dhs_div
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  dhs_pkg::dhs_meta_t                in_meta,
    input  logic [dhs_pkg::NUM_W-1:0]         in_num,
    input  logic [dhs_pkg::DEN_W-1:0]         in_den,
    output logic                              out_valid,
    output dhs_pkg::dhs_meta_t                out_meta,
    output logic [dhs_pkg::EXP_BITS-1:0]      out_quot
);
    import dhs_pkg::*;

    logic                v_reg    [EXP_BITS];
    dhs_meta_t           meta_reg [EXP_BITS];
    logic [REM_W-1:0]    rem_reg  [EXP_BITS];
    logic [DEN_W-1:0]    den_reg  [EXP_BITS];
    logic [EXP_BITS-1:0] quot_reg [EXP_BITS];

    for (genvar k = 0; k < EXP_BITS; k++)
    begin : g_step
        logic                v_in;
        dhs_meta_t           meta_in;
        logic [REM_W-1:0]    rem_in;
        logic [DEN_W-1:0]    den_in;
        logic [EXP_BITS-1:0] quot_in;
        logic [REM_W-1:0]    shifted;
        logic                take;
        logic [REM_W-1:0]    rem_next;
        logic [EXP_BITS-1:0] quot_next;

        // The first step takes the front end; later steps chain.
        if (k == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign meta_in = in_meta;
            assign rem_in  = REM_W'(in_num);
            assign den_in  = in_den;
            assign quot_in = '0;
        end
        else
        begin : g_next
            assign v_in    = v_reg[k-1];
            assign meta_in = meta_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign quot_in = quot_reg[k-1];
        end

        // Trial subtraction of the divisor at the weight of this bit.
        assign shifted   = REM_W'(den_in) << (EXP_BITS - 1 - k);
        assign take      = (rem_in >= shifted);
        assign rem_next  = take ? (rem_in - shifted) : rem_in;
        assign quot_next = take ? (quot_in | (EXP_BITS'(1) << (EXP_BITS - 1 - k)))
                                : quot_in;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                meta_reg[k] <= meta_in;
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= den_in;
                quot_reg[k] <= quot_next;
            end
        end
    end

    assign out_valid = v_reg[EXP_BITS-1];
    assign out_meta  = meta_reg[EXP_BITS-1];
    assign out_quot  = quot_reg[EXP_BITS-1];

endmodule

FILE: rtl/core/dhs_exp.sv
// Exponential by repeated Q0.16 factors, one multiplier per pipeline stage,
// followed by the final probability selection. Depends on dhs_pkg.
module dhs_exp
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              gauss_method,
    input  logic                              in_valid,
    input  dhs_pkg::dhs_meta_t                in_meta,
    input  logic [dhs_pkg::EXP_BITS-1:0]      in_quot,
    output logic                              out_valid,
    output dhs_pkg::dhs_result_t              out_result
);
    import dhs_pkg::*;

    logic                v_reg    [EXP_BITS];
    dhs_meta_t           meta_reg [EXP_BITS];
    logic [EXP_BITS-1:0] quot_reg [EXP_BITS];
    logic [ACC_W-1:0]    acc_reg  [EXP_BITS];

    for (genvar k = 0; k < EXP_BITS; k++)
    begin : g_factor
        logic                v_in;
        dhs_meta_t           meta_in;
        logic [EXP_BITS-1:0] quot_in;
        logic [ACC_W-1:0]    acc_in;
        logic [PROD_W-1:0]   prod;
        logic [ACC_W-1:0]    acc_next;

        if (k == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign meta_in = in_meta;
            assign quot_in = in_quot;
            assign acc_in  = ACC_ONE;
        end
        else
        begin : g_next
            assign v_in    = v_reg[k-1];
            assign meta_in = meta_reg[k-1];
            assign quot_in = quot_reg[k-1];
            assign acc_in  = acc_reg[k-1];
        end

        // Multiply by exp(-2^k/256) when bit k of the exponent is set, rounding.
        assign prod     = PROD_W'(acc_in) * PROD_W'(EXP_FACTOR[k]) + ROUND_Q16;
        assign acc_next = quot_in[k] ? prod[PROD_W-1:16] : acc_in;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                meta_reg[k] <= meta_in;
                quot_reg[k] <= quot_in;
                acc_reg[k]  <= acc_next;
            end
        end
    end

    dhs_meta_t        last_meta;
    logic [ACC_W-1:0] last_acc;
    logic [PROB_W-1:0] gauss_prob;

    assign last_meta = meta_reg[EXP_BITS-1];
    assign last_acc  = acc_reg[EXP_BITS-1];

    // Gaussian value with its special cases, saturated to just below 1.0.
    always_comb
    begin
        if (last_meta.zero_spread)
        begin
            gauss_prob = last_meta.zero_diff ? PROB_ONE : PROB_ZERO;
        end
        else if (last_meta.overflow)
        begin
            gauss_prob = PROB_ZERO;
        end
        else if (last_acc[ACC_W-1])
        begin
            gauss_prob = PROB_ONE;
        end
        else
        begin
            gauss_prob = last_acc[PROB_W-1:0];
        end
    end

    // Final result: unassigned gives zero; else one, or the Gaussian value.
    always_comb
    begin
        out_result.tag      = last_meta.tag;
        out_result.assigned = last_meta.assigned;
        if (!last_meta.assigned)
        begin
            out_result.probability = PROB_ZERO;
        end
        else if (gauss_method)
        begin
            out_result.probability = gauss_prob;
        end
        else
        begin
            out_result.probability = PROB_ONE;
        end
    end

    assign out_valid = v_reg[EXP_BITS-1];

endmodule

FILE: rtl/core/dhs_out_buf.sv
// Two-entry output buffer that decouples the pipeline from the receiver and
// produces the pipeline enable from its own fill level. Depends on dhs_pkg.
module dhs_out_buf
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push_valid,
    input  dhs_pkg::dhs_result_t    push_data,
    output logic                    room,
    output logic                    out_valid,
    input  logic                    out_ready,
    output dhs_pkg::dhs_result_t    out_data
);
    import dhs_pkg::*;

    logic [1:0]  fill_reg, fill_next;
    dhs_result_t slot0_reg, slot0_next;
    dhs_result_t slot1_reg, slot1_next;
    logic        push, pop;

    // The pipeline moves whenever the buffer is not full.
    assign room      = (fill_reg != 2'd2);
    assign out_valid = (fill_reg != 2'd0);
    assign out_data  = slot0_reg;
    assign push      = push_valid && room;
    assign pop       = out_valid && out_ready;

    // Head and second slot update.
    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (pop)
        begin
            slot0_next = (fill_reg == 2'd2) ? slot1_reg : push_data;
        end
        else if (push && (fill_reg == 2'd0))
        begin
            slot0_next = push_data;
        end
        if (push && !pop && (fill_reg == 2'd1))
        begin
            slot1_next = push_data;
        end
        fill_next = 2'(fill_reg + {1'b0, push} - {1'b0, pop});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= 2'd0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

FILE: rtl/core/depth_difference_hole_score_unit.sv
// Depth difference hole scorer, top level.
// Holds the configuration registers and joins front end, divider, exponential
// and output buffer. Depends on dhs_pkg and all dhs_ modules.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one candidate per transfer: four
//   corner depths, the keypoint depth and a tag. Output channel
//   (out_valid/out_ready) returns one result per candidate, in order: the tag,
//   the assigned flag and the Q0.16 probability.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
//   ready; write it only while no candidate is in flight.
//   Throughput: one candidate per cycle while the output buffer has room. Each
//   candidate passes through six front-end stages, twelve divider stages
//   (one quotient bit each), twelve multiplier stages (one exponent factor
//   each) and the output register.
//   When the receiver stalls, the two-entry output buffer keeps taking
//   results; once it is full the whole pipeline holds and in_ready drops.
//   No result is lost or repeated.
//   Reset clears all valid bits and the buffer and loads the register
//   defaults: window 0 to 1000 mm, binary method, centre 0, spread 100 mm.
module depth_difference_hole_score_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [dhs_pkg::DEPTH_W-1:0]       corner_depth_0,
    input  logic [dhs_pkg::DEPTH_W-1:0]       corner_depth_1,
    input  logic [dhs_pkg::DEPTH_W-1:0]       corner_depth_2,
    input  logic [dhs_pkg::DEPTH_W-1:0]       corner_depth_3,
    input  logic [dhs_pkg::DEPTH_W-1:0]       keypoint_depth,
    input  logic [dhs_pkg::TAG_W-1:0]         hole_tag,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [dhs_pkg::TAG_W-1:0]         hole_tag_out,
    output logic                              assigned,
    output logic [dhs_pkg::PROB_W-1:0]        probability,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dhs_pkg::CIDX_W-1:0]        cfg_index,
    input  logic [dhs_pkg::CFG_W-1:0]         cfg_data
);
    import dhs_pkg::*;

    logic signed [CFG_W-1:0] min_cutoff_reg, max_cutoff_reg, gauss_center_reg;
    logic                    method_reg;
    logic [DEPTH_W-1:0]      gauss_spread_reg;

    logic                    en;
    logic                    front_valid, div_valid, exp_valid;
    dhs_meta_t               front_meta, div_meta;
    logic [NUM_W-1:0]        front_num;
    logic [DEN_W-1:0]        front_den;
    logic [EXP_BITS-1:0]     div_quot;
    dhs_result_t             exp_result, buf_data;

    // Configuration registers; indexes beyond the list are ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_cutoff_reg   <= MIN_CUTOFF_RST;
            max_cutoff_reg   <= MAX_CUTOFF_RST;
            method_reg       <= METHOD_RST;
            gauss_center_reg <= GAUSS_CENTER_RST;
            gauss_spread_reg <= GAUSS_SPREAD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MIN_CUTOFF:    min_cutoff_reg   <= cfg_data;
                CFG_MAX_CUTOFF:    max_cutoff_reg   <= cfg_data;
                CFG_ASSIGN_METHOD: method_reg       <= cfg_data[0];
                CFG_GAUSS_CENTER:  gauss_center_reg <= cfg_data;
                CFG_GAUSS_SPREAD:  gauss_spread_reg <= cfg_data[DEPTH_W-1:0];
                default:           ;
            endcase
        end
    end

    // The pipeline advances as one whenever the output buffer has room.
    assign in_ready = en;

    dhs_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .in_valid       (in_valid),
        .corner_depth_0 (corner_depth_0),
        .corner_depth_1 (corner_depth_1),
        .corner_depth_2 (corner_depth_2),
        .corner_depth_3 (corner_depth_3),
        .keypoint_depth (keypoint_depth),
        .hole_tag       (hole_tag),
        .min_cutoff     (min_cutoff_reg),
        .max_cutoff     (max_cutoff_reg),
        .gauss_center   (gauss_center_reg),
        .gauss_spread   (gauss_spread_reg),
        .out_valid      (front_valid),
        .out_meta       (front_meta),
        .out_num        (front_num),
        .out_den        (front_den)
    );

    dhs_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .in_meta   (front_meta),
        .in_num    (front_num),
        .in_den    (front_den),
        .out_valid (div_valid),
        .out_meta  (div_meta),
        .out_quot  (div_quot)
    );

    dhs_exp u_exp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .gauss_method (method_reg),
        .in_valid     (div_valid),
        .in_meta      (div_meta),
        .in_quot      (div_quot),
        .out_valid    (exp_valid),
        .out_result   (exp_result)
    );

    dhs_out_buf u_out_buf
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (exp_valid),
        .push_data  (exp_result),
        .room       (en),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (buf_data)
    );

    assign hole_tag_out = buf_data.tag;
    assign assigned     = buf_data.assigned;
    assign probability  = buf_data.probability;

endmodule

FILE: rtl/core/dhs_checker.sv
// Port-level checks of the depth difference hole scorer, bound to the top
// level. Depends on dhs_pkg.
module dhs_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_ready,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [dhs_pkg::TAG_W-1:0]         hole_tag_out,
    input  logic                              assigned,
    input  logic [dhs_pkg::PROB_W-1:0]        probability,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready
);
    import dhs_pkg::*;

    // A stalled result stays presented and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hole_tag_out)
            && $stable(assigned) && $stable(probability))
        else $error("result changed while stalled");

    // An unassigned hole always carries a zero probability.
    a_unassigned_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !assigned |-> probability == PROB_ZERO)
        else $error("unassigned result with non-zero probability");

    // The input only backs up when results are waiting at the output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result pending");

    // A full buffer with nothing taken keeps the input stalled.
    a_stall_persist: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready && !out_ready |=> !in_ready)
        else $error("input released without a result transfer");

    // Configuration writes are never refused.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind depth_difference_hole_score_unit dhs_checker u_dhs_checker (.*);
